[src/swam_pkg.sv]
// Shared types and constants for the sliding window anagram matcher.
`default_nettype none

package swam_pkg;

   // Field widths fixed by the word format
   localparam int LETTER_W = 5;
   localparam int TYPE_W   = 2;
   localparam int POS_W    = 16;

   // Stream word widths: fields padded up to whole bytes
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   // Defaults for the top level parameters
   localparam int MAX_PATTERN_DEFAULT = 64;
   localparam int ALPHABET_DEFAULT    = 26;

   typedef enum logic [TYPE_W-1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_PATTERN = 2'd1,
      REQ_TEXT    = 2'd2
   } req_kind_type;

   // Per-letter lane control, one set per letter
   typedef struct packed {
      logic clear;     // drop both counts
      logic need_inc;  // pattern letter lands on this lane
      logic sel_in;    // text letter entering the window is this lane
      logic sel_out;   // letter leaving the window is this lane
   } lane_ctrl_type;

   typedef struct packed {
      logic take;      // entering letter was still needed
      logic give;      // leaving letter was within the need
   } lane_stat_type;

endpackage

`default_nettype wire

[src/swam_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/swam_lane.sv]
// One letter lane: needed count and window count for a single letter.
`default_nettype none

module swam_lane #(
   parameter int CW = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire swam_pkg::lane_ctrl_type ctrl,
   output swam_pkg::lane_stat_type      stat
);
   import swam_pkg::*;

   logic [CW-1:0] need_ff;
   logic [CW-1:0] need_in;
   logic [CW-1:0] win_ff;
   logic [CW-1:0] win_in;
   logic [CW-1:0] win_mid;
   logic          has_need;
   logic          fits;

   always_comb begin
      has_need = (need_ff != '0);
      win_mid  = win_ff + CW'(ctrl.sel_in && has_need);
      fits     = (win_mid <= need_ff);
      need_in  = need_ff + CW'(ctrl.need_inc);
      win_in   = win_mid;
      if (ctrl.sel_out && has_need && (win_mid != '0)) begin
         win_in = win_mid - CW'(1);
      end
      stat.take = ctrl.sel_in && has_need && fits;
      stat.give = ctrl.sel_out && has_need && fits;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         need_ff <= '0;
         win_ff  <= '0;
      end else begin
         need_ff <= need_in;
         win_ff  <= win_in;
      end
   end

endmodule

`default_nettype wire

[src/sliding_window_anagram_match.sv]
// Top level of the streaming sliding window anagram matcher.
// Usage:
//   req channel: one word per request. tuser carries the request kind
//   (clear, pattern letter, text letter), tdata the letter index.
//   A clear word drops all counts; pattern words build the need table
//   (overflow flag past MAX_PATTERN); text words slide the window.
//   rsp channel: one word per text word, none for other words: the
//   window match flag, a sticky found flag, the text index and overflow.
// Timing:
//   An accepted word is held in the input register and worked on from
//   there; its result is registered in the output register, from which
//   it is taken. One word per cycle is sustained while rsp_tready stays
//   high. The leaving letter of the window is prefetched from the history
//   RAM through its registered read, with a bypass for a same-cycle write
//   to that entry.
// Reset and stalls:
//   Reset empties both registers and clears all counts; history RAM
//   contents are not cleared. When rsp_tready is low the result holds
//   and the input register holds one more word; req_tready drops only
//   while both are full.
`default_nettype none

module sliding_window_anagram_match #(
   parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEFAULT,
   parameter int ALPHABET    = swam_pkg::ALPHABET_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: [4:0] letter, [7:5] zero
   input  wire logic [swam_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: [1:0] req_type
   input  wire logic [swam_pkg::TYPE_W-1:0]      req_tuser,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // rsp_tdata: [0] window_match, [1] found_any, [17:2] text_position,
   //            [18] pattern_overflow, [23:19] zero
   output logic [swam_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready
);
   import swam_pkg::*;

   localparam int HW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // input register
   logic                in_vld_ff, in_vld_in;
   req_kind_type        in_kind_ff;
   logic [LETTER_W-1:0] in_letter_ff;

   // result register
   logic             rsp_vld_ff, rsp_vld_in;
   logic             rsp_match_ff, rsp_found_ff, rsp_ovf_ff;
   logic [POS_W-1:0] rsp_pos_ff;

   // matcher state
   logic [CW-1:0]       plen_ff, plen_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [HW-1:0]       head_ff, head_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                found_ff, found_in;
   logic                ovf_ff, ovf_in;
   logic                byp_ff, byp_in;
   logic [LETTER_W-1:0] byp_letter_ff;

   logic                go;
   logic                do_clear, do_pat, txt_live;
   logic                c_in_alpha;
   logic [CW-1:0]       fill_mid;
   logic                full;
   logic [CW-1:0]       rem_mid;
   logic                match;
   logic                any_take, any_give;
   logic [LETTER_W-1:0] old_letter, ram_q;
   logic                wr_en;
   logic [HW-1:0]       hp1, rd_addr;

   lane_ctrl_type       lane_ctrl [ALPHABET];
   lane_stat_type       lane_stat [ALPHABET];
   logic [ALPHABET-1:0] take_vec, give_vec;

   // Work happens when the result register is free or being emptied
   assign go         = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || go;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !go);

   assign c_in_alpha = (32'(in_letter_ff) < 32'(ALPHABET));
   assign do_clear   = go && (in_kind_ff == REQ_CLEAR);
   assign do_pat     = go && (in_kind_ff == REQ_PATTERN) && (pos_ff == '0) && c_in_alpha
                       && (plen_ff != CW'(MAX_PATTERN));
   assign txt_live   = go && (in_kind_ff == REQ_TEXT) && (plen_ff != '0);

   // Window fill after this letter enters; full means one must leave
   assign fill_mid = (fill_ff < plen_ff) ? fill_ff + CW'(1) : fill_ff;
   assign full     = (fill_mid == plen_ff);

   // Leaving letter: own letter for a one-letter pattern, else the ring
   assign old_letter = (plen_ff == CW'(1)) ? in_letter_ff :
                       (byp_ff ? byp_letter_ff : ram_q);

   for (genvar l = 0; l < ALPHABET; l++) begin : g_lane
      logic hit_in, hit_out;

      assign hit_in  = (32'(in_letter_ff) == l);
      assign hit_out = (32'(old_letter) == l);

      assign lane_ctrl[l].clear    = do_clear;
      assign lane_ctrl[l].need_inc = do_pat && hit_in;
      assign lane_ctrl[l].sel_in   = txt_live && hit_in;
      assign lane_ctrl[l].sel_out  = txt_live && full && hit_out;

      assign take_vec[l] = lane_stat[l].take;
      assign give_vec[l] = lane_stat[l].give;

      swam_lane #(
         .CW(CW)
      ) u_lane (
         .clock(clock),
         .reset(reset),
         .ctrl (lane_ctrl[l]),
         .stat (lane_stat[l])
      );
   end

   assign any_take = |take_vec;
   assign any_give = |give_vec;

   assign rem_mid = (any_take && (rem_ff != '0)) ? rem_ff - CW'(1) : rem_ff;
   assign match   = (plen_ff == '0) || (full && (rem_mid == '0));

   // History ring write for each live text letter
   assign wr_en = txt_live;

   // Next state
   always_comb begin
      plen_in  = plen_ff;
      rem_in   = rem_ff;
      fill_in  = fill_ff;
      head_in  = head_ff;
      pos_in   = pos_ff;
      found_in = found_ff;
      ovf_in   = ovf_ff;
      if (go) begin
         unique case (in_kind_ff)
            REQ_CLEAR: begin
               plen_in  = '0;
               rem_in   = '0;
               fill_in  = '0;
               head_in  = '0;
               pos_in   = '0;
               found_in = 1'b0;
               ovf_in   = 1'b0;
            end
            REQ_PATTERN: begin
               if (do_pat) begin
                  plen_in = plen_ff + CW'(1);
                  rem_in  = rem_ff + CW'(1);
               end else if ((pos_ff == '0) && c_in_alpha) begin
                  ovf_in = 1'b1;
               end
            end
            REQ_TEXT: begin
               if (pos_ff != POS_MAX) begin
                  pos_in = pos_ff + POS_W'(1);
               end
               if (match) begin
                  found_in = 1'b1;
               end
               if (txt_live) begin
                  rem_in  = rem_mid + CW'(any_give);
                  fill_in = full ? fill_mid - CW'(1) : fill_mid;
                  head_in = (head_ff == HW'(MAX_PATTERN - 1)) ? '0 : head_ff + HW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Prefetch address of the letter the next word would drop
   always_comb begin
      hp1 = (head_in == HW'(MAX_PATTERN - 1)) ? '0 : head_in + HW'(1);
      if (CW'(hp1) >= plen_in) begin
         rd_addr = HW'(CW'(hp1) - plen_in);
      end else begin
         rd_addr = HW'(CW'(hp1) + CW'(MAX_PATTERN) - plen_in);
      end
      byp_in = wr_en && (head_ff == rd_addr);
   end

   swam_ram #(
      .WIDTH(LETTER_W),
      .DEPTH(MAX_PATTERN),
      .AW   (HW)
   ) u_hist (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(head_ff),
      .wr_data(in_letter_ff),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   // Result register
   always_comb begin
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      if (go) begin
         rsp_vld_in = (in_kind_ff == REQ_TEXT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         plen_ff    <= '0;
         rem_ff     <= '0;
         fill_ff    <= '0;
         head_ff    <= '0;
         pos_ff     <= '0;
         found_ff   <= 1'b0;
         ovf_ff     <= 1'b0;
         byp_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         plen_ff    <= plen_in;
         rem_ff     <= rem_in;
         fill_ff    <= fill_in;
         head_ff    <= head_in;
         pos_ff     <= pos_in;
         found_ff   <= found_in;
         ovf_ff     <= ovf_in;
         byp_ff     <= byp_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byp_letter_ff <= in_letter_ff;
      if (req_tvalid && req_tready) begin
         in_kind_ff   <= req_kind_type'(req_tuser);
         in_letter_ff <= req_tdata[LETTER_W-1:0];
      end
      if (go && (in_kind_ff == REQ_TEXT)) begin
         rsp_match_ff <= match;
         rsp_found_ff <= found_in;
         rsp_pos_ff   <= pos_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - POS_W - 3)'(0), rsp_ovf_ff, rsp_pos_ff,
                        rsp_found_ff, rsp_match_ff};

endmodule

`default_nettype wire

[src/swam_checker.sv]
// Port-level checks for the anagram matcher, bound to the top level.
`default_nettype none

module swam_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [swam_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready
);
   import swam_pkg::*;

   // Held result word stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // Output empties on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A matching window always shows up as found
   a_match_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("window_match without found_any");

   // With the output free the input side never stalls
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // Results follow requests: none without an earlier accepted word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2) || $past(!req_tready))
      else $error("result word without a request");

endmodule

bind sliding_window_anagram_match swam_checker u_swam_checker (.*);

`default_nettype wire
